// ===== rtl/core/gas_pkg.sv =====
// Shared types, constants and helpers for the gimbal angle smoother.
`default_nettype none
package gas_pkg;

  localparam int ANGLE_W    = 16;
  localparam int HIST_DEPTH = 4;
  localparam int MODE_W     = 3;
  localparam int SUM_W      = 21;
  localparam int CFG_IDX_W  = 3;

  localparam logic signed [ANGLE_W-1:0] ANG_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANG_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

  localparam logic signed [ANGLE_W-1:0] DAMP_FLOOR   = 16'sd100;
  localparam logic signed [ANGLE_W-1:0] CENTER_LIMIT = 16'sd100;

  // weights, newest entry first; the sum is divided by 20
  localparam int PITCH_W [HIST_DEPTH] = '{10, 6, 2, 1};
  localparam int YAW_W   [HIST_DEPTH] = '{12, 4, 2, 1};

  // ceil(2^24 / 5): exact floor(x / 5) for every x below 2^22
  localparam logic [21:0] DIV5_MUL = 22'd3355444;

  localparam logic [MODE_W-1:0] CLOUD_FREE    = 3'd0;
  localparam logic [MODE_W-1:0] CLOUD_AIM     = 3'd1;
  localparam logic [MODE_W-1:0] CLOUD_AIM_ALT = 3'd2;
  localparam logic [MODE_W-1:0] PLATFORM_INIT = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_SELECT = 3'd0,
    CFG_PITCH_OFF0    = 3'd1,
    CFG_YAW_OFF0      = 3'd2,
    CFG_PITCH_OFF1    = 3'd3,
    CFG_YAW_OFF1      = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic sub_en;
    logic first;
  } damp_ctrl_t;

  function automatic logic [17:0] div5(input logic [19:0] x);
    logic [43:0] prod;
    prod = 44'(x) * 44'(DIV5_MUL);
    return prod[41:24];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gas_damp.sv =====
// Offset subtraction, saturation and overshoot damping for one angle.
`default_nettype none
module gas_damp import gas_pkg::*; (
  input  logic signed [ANGLE_W-1:0] raw,
  input  logic signed [ANGLE_W-1:0] offset,
  input  logic signed [ANGLE_W-1:0] last,
  input  damp_ctrl_t                ctrl,
  output logic signed [ANGLE_W-1:0] angle
);

  logic signed [ANGLE_W:0]   diff;
  logic signed [ANGLE_W-1:0] sat_angle;
  logic [ANGLE_W:0]          mag_last;
  logic [17:0]               five_a;
  logic [17:0]               six_last;
  logic [16:0]               seven_half;
  logic [17:0]               scaled;
  logic                      big;

  always_comb begin
    if (ctrl.sub_en) begin
      diff = {raw[ANGLE_W-1], raw} - {offset[ANGLE_W-1], offset};
    end else begin
      diff = {raw[ANGLE_W-1], raw};
    end
    if (diff[ANGLE_W] != diff[ANGLE_W-1]) begin
      sat_angle = diff[ANGLE_W] ? ANG_MIN : ANG_MAX;
    end else begin
      sat_angle = diff[ANGLE_W-1:0];
    end

    mag_last = last[ANGLE_W-1] ? (17'd0 - {last[ANGLE_W-1], last}) : {1'b0, last};
    five_a     = 18'(sat_angle[ANGLE_W-2:0]) * 18'd5;
    six_last   = 18'(mag_last) * 18'd6;
    seven_half = 17'((18'(sat_angle[ANGLE_W-2:0]) * 18'd7) >> 1);
    scaled     = div5({3'b000, seven_half});

    big = !sat_angle[ANGLE_W-1] && (sat_angle > DAMP_FLOOR) && (five_a > six_last);
    angle = (!ctrl.first && big) ? scaled[ANGLE_W-1:0] : sat_angle;
  end

endmodule
`default_nettype wire

// ===== rtl/core/gas_wsum.sv =====
// Weighted sum of the sent-angle history for pitch and yaw, divided by 20.
`default_nettype none
module gas_wsum import gas_pkg::*; (
  input  logic signed [ANGLE_W-1:0] pitch_hist [HIST_DEPTH],
  input  logic signed [ANGLE_W-1:0] yaw_hist   [HIST_DEPTH],
  output logic signed [ANGLE_W-1:0] pitch_avg,
  output logic signed [ANGLE_W-1:0] yaw_avg,
  output logic                      any_set
);

  logic signed [SUM_W-1:0] psum;
  logic signed [SUM_W-1:0] ysum;

  // truncating divide by 20: divide magnitude by 4, then by 5
  function automatic logic signed [ANGLE_W-1:0] div20(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0]   mag;
    logic [17:0]        q;
    logic signed [18:0] qs;
    mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    q   = div5({2'b00, mag[19:2]});
    qs  = s[SUM_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    return qs[ANGLE_W-1:0];
  endfunction

  always_comb begin
    psum    = '0;
    ysum    = '0;
    any_set = 1'b0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      psum    = psum + SUM_W'(pitch_hist[i]) * SUM_W'(PITCH_W[i]);
      ysum    = ysum + SUM_W'(yaw_hist[i]) * SUM_W'(YAW_W[i]);
      any_set = any_set | (|pitch_hist[i]) | (|yaw_hist[i]);
    end
    pitch_avg = div20(psum);
    yaw_avg   = div20(ysum);
  end

endmodule
`default_nettype wire

// ===== rtl/core/gimbal_angle_smoother.sv =====
// Gimbal angle smoother top level: input stage, state, result stage.
//
//   channel  | dir | beat contents
//   s_axis   | in  | tdata: yaw, pitch   tuser: cloud, shoot, platform
//   m_axis   | out | tdata: yaw, pitch   tuser: cloud, shoot, platform, centered
//   cfg      | in  | cfg_index, cfg_data; always ready
//
// One beat per cycle while m_axis_tready is high; beats pass input, then result register.
// The input register feeds one combinational pass that updates the history and
// mode state and loads the result register in the same cycle.
// A stalled result holds the input register; s_axis_tready drops once both are full.
// rst is synchronous: resets state, config and valid flags, and sets the first-item flag.
`default_nettype none
module gimbal_angle_smoother import gas_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // yaw_in[15:0], pitch_in[31:16]
  input  logic [8:0]           s_axis_tuser,   // cloud_in[2:0], shoot_in[5:3], platform_in[8:6]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // yaw_out[15:0], pitch_out[31:16]
  output logic [9:0]           m_axis_tuser,   // cloud_out[2:0], shoot_out[5:3],
                                               // platform_out[8:6], centered[9]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic                      camera_select;
  logic signed [ANGLE_W-1:0] pitch_off0, yaw_off0, pitch_off1, yaw_off1;

  logic                      in_valid;
  logic signed [ANGLE_W-1:0] in_yaw, in_pitch;
  logic [MODE_W-1:0]         in_cloud, in_shoot, in_platform;

  logic                      first_pending;
  logic signed [ANGLE_W-1:0] last_pitch, last_yaw;
  logic signed [ANGLE_W-1:0] pitch_hist [HIST_DEPTH];
  logic signed [ANGLE_W-1:0] yaw_hist   [HIST_DEPTH];
  logic [MODE_W-1:0]         prev_cloud, prev_shoot, prev_platform;

  logic                      out_valid;
  logic signed [ANGLE_W-1:0] out_yaw, out_pitch;
  logic [MODE_W-1:0]         out_cloud, out_shoot, out_platform;
  logic                      out_centered;

  logic                      advance;
  damp_ctrl_t                dctrl;
  logic signed [ANGLE_W-1:0] pitch_offset, yaw_offset;
  logic signed [ANGLE_W-1:0] pitch_damp, yaw_damp;
  logic signed [ANGLE_W-1:0] pitch_avg, yaw_avg;
  logic                      any_set;
  logic                      use_avg;
  logic signed [ANGLE_W-1:0] pitch_next, yaw_next;
  logic [MODE_W-1:0]         cloud_next, shoot_next, platform_next;
  logic                      centered_next;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_select <= 1'b0;
      pitch_off0    <= '0;
      yaw_off0      <= '0;
      pitch_off1    <= '0;
      yaw_off1      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAMERA_SELECT: camera_select <= cfg_data[0];
        CFG_PITCH_OFF0:    pitch_off0    <= cfg_data;
        CFG_YAW_OFF0:      yaw_off0      <= cfg_data;
        CFG_PITCH_OFF1:    pitch_off1    <= cfg_data;
        CFG_YAW_OFF1:      yaw_off1      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_yaw      <= s_axis_tdata[15:0];
      in_pitch    <= s_axis_tdata[31:16];
      in_cloud    <= s_axis_tuser[2:0];
      in_shoot    <= s_axis_tuser[5:3];
      in_platform <= s_axis_tuser[8:6];
    end
  end

  always_comb begin
    dctrl.sub_en = (in_cloud == CLOUD_AIM) || (in_cloud == CLOUD_AIM_ALT);
    dctrl.first  = first_pending;
    pitch_offset = camera_select ? pitch_off1 : pitch_off0;
    yaw_offset   = camera_select ? yaw_off1 : yaw_off0;
  end

  gas_damp u_pitch_damp (
    .raw    (in_pitch),
    .offset (pitch_offset),
    .last   (last_pitch),
    .ctrl   (dctrl),
    .angle  (pitch_damp)
  );

  gas_damp u_yaw_damp (
    .raw    (in_yaw),
    .offset (yaw_offset),
    .last   (last_yaw),
    .ctrl   (dctrl),
    .angle  (yaw_damp)
  );

  gas_wsum u_wsum (
    .pitch_hist (pitch_hist),
    .yaw_hist   (yaw_hist),
    .pitch_avg  (pitch_avg),
    .yaw_avg    (yaw_avg),
    .any_set    (any_set)
  );

  always_comb begin
    use_avg       = ((in_cloud == CLOUD_FREE) || (in_cloud == CLOUD_AIM)) && any_set;
    pitch_next    = use_avg ? pitch_avg : pitch_damp;
    yaw_next      = use_avg ? yaw_avg : yaw_damp;
    cloud_next    = use_avg ? prev_cloud : in_cloud;
    shoot_next    = use_avg ? prev_shoot : in_shoot;
    platform_next = use_avg ? prev_platform : in_platform;
    centered_next = (pitch_next <= CENTER_LIMIT) && (pitch_next >= -CENTER_LIMIT) &&
                    (yaw_next <= CENTER_LIMIT) && (yaw_next >= -CENTER_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
      last_pitch    <= '0;
      last_yaw      <= '0;
      prev_cloud    <= CLOUD_FREE;
      prev_shoot    <= '0;
      prev_platform <= PLATFORM_INIT;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        pitch_hist[i] <= '0;
        yaw_hist[i]   <= '0;
      end
    end else if (advance) begin
      first_pending <= 1'b0;
      last_pitch    <= pitch_damp;
      last_yaw      <= yaw_damp;
      prev_cloud    <= cloud_next;
      prev_shoot    <= shoot_next;
      prev_platform <= platform_next;
      pitch_hist[0] <= pitch_next;
      yaw_hist[0]   <= yaw_next;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        pitch_hist[i] <= pitch_hist[i-1];
        yaw_hist[i]   <= yaw_hist[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_yaw      <= yaw_next;
      out_pitch    <= pitch_next;
      out_cloud    <= cloud_next;
      out_shoot    <= shoot_next;
      out_platform <= platform_next;
      out_centered <= centered_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_pitch, out_yaw};
  assign m_axis_tuser  = {out_centered, out_platform, out_shoot, out_cloud};

`ifndef ASSERT_OFF
  a_first_cleared: assert property (@(posedge clk) disable iff (rst)
    advance |=> !first_pending)
    else $error("first_pending still set after an item");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready && in_valid) |-> !s_axis_tready)
    else $error("input taken while both stages are full");

  a_hist_matches_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> (pitch_hist[0] == out_pitch) && (yaw_hist[0] == out_yaw))
    else $error("history entry differs from sent angle");

  a_centered_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_centered) |->
      (out_pitch <= CENTER_LIMIT) && (out_pitch >= -CENTER_LIMIT) &&
      (out_yaw <= CENTER_LIMIT) && (out_yaw >= -CENTER_LIMIT))
    else $error("centered flag set with angle out of range");
`endif

endmodule
`default_nettype wire
